FILE: hdl/fggf_pkg.sv
// Shared types and constants for the spectral gradient filter.
// No dependencies.
package fggf_pkg;

  localparam int GRID_W = 11;
  localparam int AXIS_W = 2;
  localparam int SAMPLE_W = 32;
  localparam int FRAC_W = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_AXIS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_AXIS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_STEP = 2'd3;

  localparam logic [GRID_W-1:0] GRID_RESET = 11'd256;
  localparam logic [SAMPLE_W-1:0] STEP_RESET = 32'd16777216;

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_DIV = 2'd1;
  localparam logic [1:0] BK_FIN = 2'd2;

  typedef struct packed {
    logic [GRID_W-1:0] n;
    logic [AXIS_W-1:0] a;
    logic [AXIS_W-1:0] b;
    logic has_b;
    logic [SAMPLE_W-1:0] dk;
  } cfg_t;

endpackage

FILE: hdl/fggf_front.sv
// Front part: position counters, wavenumbers, zeroed modes and operand products.
// Three stages feeding the queue; uses fggf_pkg.
module fggf_front #(
  parameter int PW = 10,
  parameter int NUMW = 76,
  parameter int DW = 52
) (
  input  logic clk,
  input  logic rst,
  input  fggf_pkg::cfg_t cfg,
  input  logic clear_pos,
  input  logic in_valid,
  output logic in_ready,
  input  logic [fggf_pkg::SAMPLE_W-1:0] sample_re,
  input  logic [fggf_pkg::SAMPLE_W-1:0] sample_im,
  output logic push,
  input  logic push_ready,
  output logic [4+2*NUMW+DW-1:0] push_data
);
  import fggf_pkg::*;

  localparam int KW = PW + 1;
  localparam int SW = 2 * PW;

  logic [PW-1:0] outer_position, middle_position, inner_position;
  logic [KW-1:0] n_w, half, nm1;
  logic signed [KW-1:0] k0, k1, k2, ka, kb;
  logic za, zb, zero_c, last_c, differ, accept;

  function automatic logic signed [KW-1:0] wav(input logic [PW-1:0] p,
                                               input logic [KW-1:0] n, input logic [KW-1:0] h);
    logic [KW-1:0] pe;
    pe = {1'b0, p};
    return (pe > h) ? $signed(pe - n) : $signed(pe);
  endfunction

  function automatic logic signed [KW-1:0] pick(input logic signed [KW-1:0] x0,
      input logic signed [KW-1:0] x1, input logic signed [KW-1:0] x2, input logic [1:0] i);
    logic signed [KW-1:0] r;
    unique case (i)
      2'd0: r = x0;
      2'd1: r = x1;
      default: r = x2;
    endcase
    return r;
  endfunction

  function automatic logic edge_mode(input logic signed [KW-1:0] k, input logic [KW-1:0] h);
    logic [KW-1:0] m;
    m = k[KW-1] ? KW'(-k) : KW'(k);
    return (m == '0) || (m == h);
  endfunction

  always_comb begin
    n_w = KW'(cfg.n);
    half = n_w >> 1;
    nm1 = n_w - KW'(1);
    k0 = wav(outer_position, n_w, half);
    k1 = wav(middle_position, n_w, half);
    k2 = $signed({1'b0, inner_position});
    ka = pick(k0, k1, k2, cfg.a);
    kb = pick(k0, k1, k2, cfg.b);
    differ = !cfg.has_b || (cfg.a != cfg.b);
    za = differ && edge_mode(ka, half);
    zb = cfg.has_b && differ && edge_mode(kb, half);
    zero_c = (k0 == '0 && k1 == '0 && k2 == '0) || za || zb;
    last_c = ({1'b0, outer_position} >= nm1) && ({1'b0, middle_position} >= nm1)
             && ({1'b0, inner_position} >= half);
  end

  // stage valids and flow
  logic v1, v2, v3, adv1, adv2, adv3;
  assign adv3 = !v3 || push_ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_ready = adv1;
  assign accept = in_valid && in_ready;
  assign push = v3;

  always_ff @(posedge clk) begin
    if (rst || clear_pos) begin
      outer_position <= '0;
      middle_position <= '0;
      inner_position <= '0;
    end else if (accept) begin
      if ({1'b0, inner_position} >= half) begin
        inner_position <= '0;
        if ({1'b0, middle_position} >= nm1) begin
          middle_position <= '0;
          outer_position <= ({1'b0, outer_position} >= nm1) ? '0 : outer_position + 1'b1;
        end else begin
          middle_position <= middle_position + 1'b1;
        end
      end else begin
        inner_position <= inner_position + 1'b1;
      end
    end
  end

  // stage 1
  logic signed [KW-1:0] s1_k0, s1_k1, s1_k2, s1_ka, s1_kb;
  logic s1_zero, s1_last, s1_hasb;
  logic signed [SAMPLE_W-1:0] s1_re, s1_im;

  // stage 2
  logic [SW-1:0] s2_ksq, s2_kmag;
  logic [SAMPLE_W-1:0] s2_xa, s2_xb;
  logic s2_nega, s2_negb, s2_zero, s2_last, s2_hasb;

  logic signed [2*KW-1:0] sq0, sq1, sq2, kab;
  logic [SW+1:0] ksq_sum;
  logic signed [SAMPLE_W-1:0] xa_s, xb_s;
  logic ksign;
  always_comb begin
    sq0 = s1_k0 * s1_k0;
    sq1 = s1_k1 * s1_k1;
    sq2 = s1_k2 * s1_k2;
    ksq_sum = (SW+2)'(sq0) + (SW+2)'(sq1) + (SW+2)'(sq2);
    kab = s1_ka * s1_kb;
    xa_s = s1_hasb ? s1_re : s1_im;
    xb_s = s1_hasb ? s1_im : s1_re;
    ksign = s1_hasb ? kab[2*KW-1] : s1_ka[KW-1];
  end

  // stage 3
  logic [NUMW-1:0] s3_na, s3_nb;
  logic [DW-1:0] s3_d;
  logic s3_nega, s3_negb, s3_zero, s3_last;
  logic [SAMPLE_W+SW-1:0] ma, mb;
  always_comb begin
    ma = SAMPLE_W'(s2_xa) * s2_kmag;
    mb = SAMPLE_W'(s2_xb) * s2_kmag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= accept;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
    if (adv1 && accept) begin
      s1_k0 <= k0;
      s1_k1 <= k1;
      s1_k2 <= k2;
      s1_ka <= ka;
      s1_kb <= kb;
      s1_zero <= zero_c;
      s1_last <= last_c;
      s1_hasb <= cfg.has_b;
      s1_re <= $signed(sample_re);
      s1_im <= $signed(sample_im);
    end
    if (adv2 && v1) begin
      s2_ksq <= SW'(ksq_sum);
      s2_kmag <= s1_hasb ? (kab[2*KW-1] ? SW'(-kab) : SW'(kab))
                         : (s1_ka[KW-1] ? SW'(-s1_ka) : SW'(s1_ka));
      s2_xa <= xa_s[SAMPLE_W-1] ? SAMPLE_W'(-xa_s) : SAMPLE_W'(xa_s);
      s2_xb <= xb_s[SAMPLE_W-1] ? SAMPLE_W'(-xb_s) : SAMPLE_W'(xb_s);
      s2_nega <= xa_s[SAMPLE_W-1] ^ ksign;
      s2_negb <= xb_s[SAMPLE_W-1] ^ ksign ^ !s1_hasb;
      s2_zero <= s1_zero;
      s2_last <= s1_last;
      s2_hasb <= s1_hasb;
    end
    if (adv3 && v2) begin
      s3_na <= s2_hasb ? NUMW'(ma) : (NUMW'(ma) << FRAC_W);
      s3_nb <= s2_hasb ? NUMW'(mb) : (NUMW'(mb) << FRAC_W);
      s3_d <= s2_hasb ? DW'(s2_ksq) : DW'(cfg.dk * s2_ksq);
      s3_nega <= s2_nega;
      s3_negb <= s2_negb;
      s3_zero <= s2_zero;
      s3_last <= s2_last;
    end
  end

  assign push_data = {s3_zero, s3_last, s3_nega, s3_negb, s3_na, s3_nb, s3_d};
endmodule

FILE: hdl/fggf_queue.sv
// Two-entry queue between the front and back parts.
// Generic width; no package use beyond house style.
module fggf_queue #(
  parameter int W = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  logic [W-1:0] wr_data,
  output logic rd_valid,
  input  logic rd_pop,
  output logic [W-1:0] rd_data
);
  logic [W-1:0] mem [2];
  logic wp, rp;
  logic [1:0] count;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp <= !wp;
      if (rd_pop && rd_valid) rp <= !rp;
      count <= count + 2'((wr_valid && wr_ready) ? 1 : 0) - 2'((rd_pop && rd_valid) ? 1 : 0);
    end
  end
endmodule

FILE: hdl/fggf_back.sv
// Back part: two restoring divider lanes sharing a divisor, rounding and saturation.
// Drives the output register; uses fggf_pkg.
module fggf_back #(
  parameter int NUMW = 76,
  parameter int DW = 52
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_pop,
  input  logic [4+2*NUMW+DW-1:0] q_data,
  output logic out_valid,
  input  logic out_ready,
  output logic [fggf_pkg::SAMPLE_W-1:0] result_re,
  output logic [fggf_pkg::SAMPLE_W-1:0] result_im,
  output logic saturated,
  output logic grid_end
);
  import fggf_pkg::*;

  localparam int CW = $clog2(NUMW + 1);
  localparam logic [NUMW:0] NEG_LIM = (NUMW+1)'(33'h080000000);
  localparam logic [NUMW:0] POS_LIM = (NUMW+1)'(33'h07fffffff);

  logic [1:0] state;
  logic [CW-1:0] cnt;
  logic [NUMW-1:0] na, nb, qa, qb, qa_next, qb_next, na_next, nb_next;
  logic [DW-1:0] d, ra, rb, ra_next, rb_next;
  logic zero, last, nega, negb;

  function automatic logic [DW:0] shift_in(input logic [DW-1:0] r, input logic b);
    return {r, b};
  endfunction

  logic [DW:0] rsa, rsb;
  logic gea, geb;
  always_comb begin
    rsa = shift_in(ra, na[NUMW-1]);
    rsb = shift_in(rb, nb[NUMW-1]);
    gea = rsa >= {1'b0, d};
    geb = rsb >= {1'b0, d};
    ra_next = gea ? DW'(rsa - {1'b0, d}) : rsa[DW-1:0];
    rb_next = geb ? DW'(rsb - {1'b0, d}) : rsb[DW-1:0];
    qa_next = {qa[NUMW-2:0], gea};
    qb_next = {qb[NUMW-2:0], geb};
    na_next = na << 1;
    nb_next = nb << 1;
  end

  function automatic logic [SAMPLE_W:0] finish(input logic [NUMW-1:0] q,
      input logic [DW-1:0] r, input logic [DW-1:0] dv, input logic neg);
    logic [NUMW:0] qx;
    logic rnd, s;
    logic [SAMPLE_W-1:0] v;
    rnd = {r, 1'b0} >= {1'b0, dv};
    qx = {1'b0, q} + (NUMW+1)'(rnd);
    if (neg) begin
      s = qx > NEG_LIM;
      v = s ? 32'h80000000 : SAMPLE_W'(-qx[SAMPLE_W-1:0]);
    end else begin
      s = qx > POS_LIM;
      v = s ? 32'h7fffffff : qx[SAMPLE_W-1:0];
    end
    return {s, v};
  endfunction

  logic [SAMPLE_W:0] fa, fb;
  always_comb begin
    fa = finish(qa, ra, d, nega);
    fb = finish(qb, rb, d, negb);
  end

  assign q_pop = (state == BK_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != BK_FIN)) out_valid <= 1'b0;
      unique case (state)
        BK_IDLE: begin
          if (q_valid) begin
            {zero, last, nega, negb, na, nb, d} <= q_data;
            qa <= '0;
            qb <= '0;
            ra <= '0;
            rb <= '0;
            cnt <= '0;
            state <= q_data[4+2*NUMW+DW-1] ? BK_FIN : BK_DIV;
          end
        end
        BK_DIV: begin
          qa <= qa_next;
          qb <= qb_next;
          ra <= ra_next;
          rb <= rb_next;
          na <= na_next;
          nb <= nb_next;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(NUMW - 1)) state <= BK_FIN;
        end
        BK_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            result_re <= zero ? '0 : fa[SAMPLE_W-1:0];
            result_im <= zero ? '0 : fb[SAMPLE_W-1:0];
            saturated <= !zero && (fa[SAMPLE_W] || fb[SAMPLE_W]);
            grid_end <= last;
            state <= BK_IDLE;
          end
        end
        default: state <= BK_IDLE;
      endcase
    end
  end
endmodule

FILE: hdl/fourier_green_gradient_filter.sv
// Top level of the spectral gradient filter: configuration registers,
// front part, queue and divider back part. Uses fggf_pkg.
//
// Usage: samples enter on in_valid/in_ready as sample_re/sample_im, one per
// beat, in half-complex order over an N x N x (N/2+1) grid, last index fastest.
// Results leave on out_valid/out_ready, one beat per input beat, in order,
// with saturated and grid_end flags. Registers are written on cfg_valid/
// cfg_ready (always ready) with cfg_index and cfg_data; the user must write the
// registers only while the block is idle, which the block does not enforce;
// writing grid_size restarts the grid position. Pipeline: three front
// stages, queue, then a back part whose bit-serial divider lanes divide each
// item in turn (DC and zeroed modes skip the divide); it takes the next item
// from the queue only after the current result is in the output register.
// Reset clears positions and loads register reset values. When the receiver
// stalls, the finished result holds in the output register, the back part
// works on the next item, and the queue and front stages fill before in_ready
// drops.
module fourier_green_gradient_filter #(
  parameter int MAX_GRID = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [fggf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [fggf_pkg::SAMPLE_W-1:0] sample_re,
  input  logic [fggf_pkg::SAMPLE_W-1:0] sample_im,
  output logic out_valid,
  input  logic out_ready,
  output logic [fggf_pkg::SAMPLE_W-1:0] result_re,
  output logic [fggf_pkg::SAMPLE_W-1:0] result_im,
  output logic saturated,
  output logic grid_end
);
  import fggf_pkg::*;

  localparam int PW = (MAX_GRID > 2048) ? 11 : $clog2(MAX_GRID);
  localparam int NUMW = 56 + 2 * PW;
  localparam int DW = 32 + 2 * PW;
  localparam int EW = 4 + 2 * NUMW + DW;
  localparam int TOP = (MAX_GRID / 2) * 2;

  function automatic logic [GRID_W-1:0] eff_n(input logic [GRID_W-1:0] g);
    int v;
    v = int'(g) & ~1;
    if (v < 4) v = 4;
    if (v > TOP) v = TOP;
    return GRID_W'(v);
  endfunction

  cfg_t cfg;
  logic cfg_we, clear_pos;

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg_ready;
  assign clear_pos = cfg_we && (cfg_index == CFG_GRID_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.n <= eff_n(GRID_RESET);
      cfg.a <= 2'd0;
      cfg.b <= 2'd0;
      cfg.has_b <= 1'b0;
      cfg.dk <= STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_SIZE: cfg.n <= eff_n(cfg_data[GRID_W-1:0]);
        CFG_FIRST_AXIS: cfg.a <= (cfg_data[1:0] == 2'd3) ? 2'd2 : cfg_data[1:0];
        CFG_SECOND_AXIS: begin
          cfg.has_b <= !cfg_data[2];
          cfg.b <= (cfg_data[1:0] == 2'd3) ? 2'd2 : cfg_data[1:0];
        end
        CFG_WAVE_STEP: cfg.dk <= (cfg_data == '0) ? 32'd1 : cfg_data;
        default: ;
      endcase
    end
  end

  logic push, push_ready, q_valid, q_pop;
  logic [EW-1:0] push_data, q_data;

  fggf_front #(.PW(PW), .NUMW(NUMW), .DW(DW)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .clear_pos(clear_pos),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample_re(sample_re), .sample_im(sample_im),
    .push(push), .push_ready(push_ready), .push_data(push_data)
  );

  fggf_queue #(.W(EW)) u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(push), .wr_ready(push_ready), .wr_data(push_data),
    .rd_valid(q_valid), .rd_pop(q_pop), .rd_data(q_data)
  );

  fggf_back #(.NUMW(NUMW), .DW(DW)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_re(result_re), .result_im(result_im),
    .saturated(saturated), .grid_end(grid_end)
  );
endmodule

FILE: tb/sv/fggf_checker.sv
// Checker for fourier_green_gradient_filter: tracks config writes and input beats,
// predicts each filtered sample and compares it with the output beats.
// Depends on fggf_pkg.
module fggf_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [fggf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] sample_re,
  input  logic [31:0] sample_im,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] result_re,
  input  logic [31:0] result_im,
  input  logic        saturated,
  input  logic        grid_end,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  import fggf_pkg::*;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        sat;
    logic        last;
  } filt_t;

  filt_t       filt_q[$];
  logic [10:0] n_reg;
  logic [1:0]  axis_a;
  logic [2:0]  axis_b;
  logic [31:0] dk_reg;
  int          pos0, pos1, pos2;

  function automatic logic [31:0] scale_div(longint x, longint km, bit up24, bit flip,
                                            logic [127:0] d, ref bit sat);
    logic [127:0] num, q, r, mag;
    bit neg;
    num = 128'(x < 0 ? -x : x) * 128'(km < 0 ? -km : km);
    neg = ((x < 0) != (km < 0)) ^ flip;
    if (num == 0) return 32'd0;
    if (up24) num = num << 24;
    q = num / d;
    r = num % d;
    if (r >= d - r) q = q + 1;
    if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
    mag = q;
    if (neg) begin
      if (mag > 128'h8000_0000) begin
        sat = 1;
        mag = 128'h8000_0000;
      end
      return 32'(-mag);
    end
    if (mag > 128'h7fff_ffff) begin
      sat = 1;
      mag = 128'h7fff_ffff;
    end
    return mag[31:0];
  endfunction

  function automatic filt_t predict_filter(logic [31:0] xre, logic [31:0] xim);
    filt_t  f;
    int     n, half, a, b, sb;
    longint k[3];
    bit     has_b, differ, zero, sat;
    logic [127:0] ksq, d;
    n = int'(n_reg) & ~1;
    if (n < 4) n = 4;
    if (n > 1024) n = 1024;
    half = n / 2;
    a = axis_a > 2 ? 2 : int'(axis_a);
    sb = int'($signed(axis_b));
    has_b = sb >= 0;
    b = has_b ? (sb > 2 ? 2 : sb) : 0;
    differ = !has_b || a != b;
    k[0] = pos0 > half ? pos0 - n : pos0;
    k[1] = pos1 > half ? pos1 - n : pos1;
    k[2] = pos2;
    zero = (k[0] == 0 && k[1] == 0 && k[2] == 0);
    if (differ && (k[a] == 0 || k[a] == half || k[a] == -half)) zero = 1;
    if (has_b && differ && (k[b] == 0 || k[b] == half || k[b] == -half)) zero = 1;
    sat = 0;
    f = '0;
    if (!zero) begin
      ksq = 128'(k[0] * k[0] + k[1] * k[1] + k[2] * k[2]);
      if (has_b) begin
        f.re = scale_div(longint'($signed(xre)), k[a] * k[b], 0, 0, ksq, sat);
        f.im = scale_div(longint'($signed(xim)), k[a] * k[b], 0, 0, ksq, sat);
      end else begin
        d = 128'(dk_reg == 0 ? 32'd1 : dk_reg) * ksq;
        f.re = scale_div(longint'($signed(xim)), k[a], 1, 0, d, sat);
        f.im = scale_div(longint'($signed(xre)), k[a], 1, 1, d, sat);
      end
    end
    f.sat = sat;
    f.last = pos0 >= n - 1 && pos1 >= n - 1 && pos2 >= half;
    if (pos2 >= half) begin
      pos2 = 0;
      if (pos1 >= n - 1) begin
        pos1 = 0;
        pos0 = pos0 >= n - 1 ? 0 : pos0 + 1;
      end else begin
        pos1++;
      end
    end else begin
      pos2++;
    end
    return f;
  endfunction

  always @(posedge clk) begin
    filt_t exp_f;
    if (rst) begin
      n_reg <= GRID_RESET;
      axis_a <= '0;
      axis_b <= 3'b111;
      dk_reg <= STEP_RESET;
      pos0 = 0;
      pos1 = 0;
      pos2 = 0;
      filt_q.delete();
      fail_count <= 0;
      pending <= 0;
      checked <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GRID_SIZE: begin
            n_reg <= cfg_data[10:0];
            pos0 = 0;
            pos1 = 0;
            pos2 = 0;
          end
          CFG_FIRST_AXIS: axis_a <= cfg_data[1:0];
          CFG_SECOND_AXIS: axis_b <= cfg_data[2:0];
          CFG_WAVE_STEP: dk_reg <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) filt_q.push_back(predict_filter(sample_re, sample_im));
      if (out_valid && out_ready) begin
        checked <= checked + 1;
        if (filt_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: re %h im %h", $time,
                   result_re, result_im);
          fail_count <= fail_count + 1;
        end else begin
          exp_f = filt_q.pop_front();
          if (exp_f !== {result_re, result_im, saturated, grid_end}) begin
            $display("%0t: mismatch exp re %h im %h sat %b end %b, got re %h im %h sat %b end %b",
                     $time, exp_f.re, exp_f.im, exp_f.sat, exp_f.last,
                     result_re, result_im, saturated, grid_end);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= filt_q.size();
    end
  end
endmodule

FILE: tb/sv/tb_fourier_green_gradient_filter.sv
// Testbench top for fourier_green_gradient_filter: drives config phases and
// sample beats with random idling; fggf_checker predicts and compares.
// Depends on fggf_pkg, fggf_checker and the block itself.
module tb_fourier_green_gradient_filter;
  import fggf_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] sample_re = '0;
  logic [31:0] sample_im = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] result_re, result_im;
  logic        saturated, grid_end;
  int          fail_count, pending, checked;
  bit          idle_on = 1'b1;
  int          stall_left = 0;
  int          sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fourier_green_gradient_filter i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .sample_re(sample_re), .sample_im(sample_im),
    .out_valid(out_valid), .out_ready(out_ready), .result_re(result_re),
    .result_im(result_im), .saturated(saturated), .grid_end(grid_end)
  );

  fggf_checker i_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .sample_re(sample_re), .sample_im(sample_im),
    .out_valid(out_valid), .out_ready(out_ready), .result_re(result_re),
    .result_im(result_im), .saturated(saturated), .grid_end(grid_end),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 6))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'($signed($urandom_range(0, 2047)) - 1024);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_sample(logic [31:0] re, logic [31:0] im);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_re <= re;
    sample_im <= im;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
  endtask

  int          ph_size[11] = '{4, 4, 6, 8, 3, 2047, 5, 0, 10, 4, 12};
  logic [1:0]  ph_a[11] = '{0, 1, 2, 3, 1, 2, 0, 0, 1, 2, 0};
  logic [2:0]  ph_b[11] = '{7, 0, 2, 3, 4, 1, 5, 6, 2, 7, 1};
  logic [31:0] ph_dk[11] = '{32'h0100_0000, 32'd1, 32'd1, 32'd1, 32'd0, 32'd1,
                             32'hffff_ffff, 32'd1, 32'h0000_4000, 32'h0010_0000, 32'h0200_0000};
  int          ph_items[11] = '{60, 60, 60, 60, 50, 40, 50, 50, 60, 60, 60};

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    push_sample(32'h7fff_ffff, 32'h8000_0000);
    push_sample(32'h8000_0000, 32'h7fff_ffff);
    push_sample(32'h8000_0000, 32'h8000_0000);
    push_sample(32'h7fff_ffff, 32'h7fff_ffff);
    push_sample(32'hffff_ffff, 32'd1);
    push_sample(32'd0, 32'd0);
    repeat (14) push_sample(pick_sample(), pick_sample());
    for (int p = 0; p < 11; p++) begin
      drain();
      idle_on = (p != 10) && (p != 3);
      write_reg(CFG_GRID_SIZE, ($urandom & 32'hffff_f800) | 32'(ph_size[p]));
      write_reg(CFG_FIRST_AXIS, ($urandom & 32'hffff_fffc) | 32'(ph_a[p]));
      write_reg(CFG_SECOND_AXIS, ($urandom & 32'hffff_fff8) | 32'(ph_b[p]));
      write_reg(CFG_WAVE_STEP, p >= 8 ? $urandom : ph_dk[p]);
      cfg_valid <= 1'b0;
      @(posedge clk);
      repeat (ph_items[p]) push_sample(pick_sample(), pick_sample());
    end
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
    $display("Covered %0d samples over 12 register settings, %0d results compared,",
             sent, checked);
    $display("including DC, Nyquist, odd and clamped grid sizes and saturation.");
    if (fail_count == 0) begin
      $display("tb_fourier_green_gradient_filter: PASS");
    end else begin
      $display("tb_fourier_green_gradient_filter: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_fourier_green_gradient_filter: FAIL");
    $finish;
  end
endmodule
